>>> hdl/hcg_pkg.sv
// Shared types, constants and register codes of the hit cluster grouper.
package hcg_pkg;

   localparam int FRAME_DEPTH = 64;
   localparam int IDX_W       = $clog2(FRAME_DEPTH);
   localparam int CNT_W       = IDX_W + 1;
   localparam int MAX_GROUP   = 8;
   localparam int GRP_W       = $clog2(MAX_GROUP);
   localparam int ES_W        = 16 + GRP_W;
   localparam int ESUM_W      = ES_W + 1;
   localparam int MC_W        = 8 + GRP_W;
   localparam int PROD_W      = 50;
   localparam int NUM_W       = PROD_W + GRP_W;
   localparam int DVD_W       = NUM_W + 1;
   localparam int DVS_W       = ES_W + 1;
   localparam int DC_W        = $clog2(DVD_W + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QP_W        = $clog2(QUEUE_DEPTH);
   localparam int QC_W        = QP_W + 1;
   localparam int CSR_AW      = 6;
   localparam int CSR_DW      = 64;

   localparam logic [16:0] E17_MAX = 17'h1FFFF;

   localparam logic [2:0] REG_RADIUS_SQUARED = 3'd0;
   localparam logic [2:0] REG_TIME_WINDOW    = 3'd1;
   localparam logic [2:0] REG_OVERLAP_MARGIN = 3'd2;
   localparam logic [2:0] REG_MAX_HITS       = 3'd3;
   localparam logic [2:0] REG_ENERGY_MIN     = 3'd4;
   localparam logic [2:0] REG_ENERGY_MAX     = 3'd5;

   typedef struct packed {
      logic [47:0]        hit_time;
      logic [15:0]        hit_region;
      logic signed [15:0] hit_x;
      logic signed [15:0] hit_y;
      logic signed [15:0] hit_z;
      logic [15:0]        hit_energy;
      logic [15:0]        hit_missing_energy;
      logic [7:0]         hit_missing_count;
      logic [47:0]        frame_start;
      logic [47:0]        frame_end;
      logic               frame_last;
   } req_type;

   typedef struct packed {
      logic               photon_valid;
      logic               photon_last;
      logic [47:0]        photon_time;
      logic [15:0]        photon_region;
      logic signed [15:0] photon_x;
      logic signed [15:0] photon_y;
      logic signed [15:0] photon_z;
      logic [16:0]        photon_energy;
      logic [16:0]        photon_missing_energy;
      logic [10:0]        photon_missing_count;
      logic [3:0]         photon_hit_count;
   } rsp_type;

   typedef struct packed {
      logic [47:0]        t;
      logic [15:0]        region;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic [15:0]        e;
      logic [15:0]        me;
      logic [7:0]         mc;
   } hit_type;

   typedef struct packed {
      logic [33:0] radius_squared;
      logic [31:0] time_window;
      logic [31:0] overlap_margin;
      logic [3:0]  max_hits;
      logic [16:0] energy_min;
      logic [16:0] energy_max;
   } cfg_type;

endpackage

>>> hdl/hcg_fifo.sv
// Short item queue between the front and back parts.
module hcg_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hcg_pkg::req_type push_data,
   input  logic             pop,
   output hcg_pkg::req_type pop_data,
   output logic             full,
   output logic             empty
);

   hcg_pkg::req_type q_mem [hcg_pkg::QUEUE_DEPTH];
   logic [hcg_pkg::QP_W-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [hcg_pkg::QC_W-1:0] cnt_ff, cnt_in;

   assign full     = (cnt_ff == hcg_pkg::QC_W'(hcg_pkg::QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = q_mem[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = wp_ff + 1'b1;
      end
      if (pop) begin
         rp_in = rp_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wp_ff] <= push_data;
      end
   end

endmodule

>>> hdl/hcg_front.sv
// Front part: register port and input item acceptance into the queue.
module hcg_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        queue_full,
   output logic                        queue_push,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [hcg_pkg::CSR_AW-1:0]  paddr,
   input  logic [hcg_pkg::CSR_DW-1:0]  pwdata,
   output logic [hcg_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready,
   output hcg_pkg::cfg_type            cfg
);

   hcg_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign reg_idx    = paddr[hcg_pkg::CSR_AW-1:3];
   assign pready     = 1'b1;
   assign wr_en      = psel && penable && pwrite;
   assign req_stall  = queue_full;
   assign queue_push = req_valid && !queue_full;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            hcg_pkg::REG_RADIUS_SQUARED: cfg_in.radius_squared = pwdata[33:0];
            hcg_pkg::REG_TIME_WINDOW:    cfg_in.time_window    = pwdata[31:0];
            hcg_pkg::REG_OVERLAP_MARGIN: cfg_in.overlap_margin = pwdata[31:0];
            hcg_pkg::REG_MAX_HITS:       cfg_in.max_hits       = pwdata[3:0];
            hcg_pkg::REG_ENERGY_MIN:     cfg_in.energy_min     = pwdata[16:0];
            hcg_pkg::REG_ENERGY_MAX:     cfg_in.energy_max     = pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         hcg_pkg::REG_RADIUS_SQUARED: prdata = 64'(cfg_ff.radius_squared);
         hcg_pkg::REG_TIME_WINDOW:    prdata = 64'(cfg_ff.time_window);
         hcg_pkg::REG_OVERLAP_MARGIN: prdata = 64'(cfg_ff.overlap_margin);
         hcg_pkg::REG_MAX_HITS:       prdata = 64'(cfg_ff.max_hits);
         hcg_pkg::REG_ENERGY_MIN:     prdata = 64'(cfg_ff.energy_min);
         hcg_pkg::REG_ENERGY_MAX:     prdata = 64'(cfg_ff.energy_max);
         default:                     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radius_squared <= '0;
         cfg_ff.time_window    <= '0;
         cfg_ff.overlap_margin <= '0;
         cfg_ff.max_hits       <= 4'd8;
         cfg_ff.energy_min     <= '0;
         cfg_ff.energy_max     <= hcg_pkg::E17_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hdl/hcg_div.sv
// Restoring divider for the weighted group time, one quotient bit a cycle.
module hcg_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [hcg_pkg::DVD_W-1:0]  dividend,
   input  logic [hcg_pkg::DVS_W-1:0]  divisor,
   output logic                       done,
   output logic [hcg_pkg::DVD_W-1:0]  quotient
);

   logic                       busy_ff, busy_in;
   logic [hcg_pkg::DC_W-1:0]   cnt_ff, cnt_in;
   logic [hcg_pkg::DVD_W-1:0]  quo_ff, quo_in;
   logic [hcg_pkg::DVS_W-1:0]  rem_ff, rem_in;
   logic [hcg_pkg::DVS_W-1:0]  dvs_ff, dvs_in;
   logic [hcg_pkg::DVS_W:0]    trial;

   assign done     = busy_ff && (cnt_ff == hcg_pkg::DC_W'(hcg_pkg::DVD_W));
   assign quotient = quo_ff;
   assign trial    = {rem_ff, quo_ff[hcg_pkg::DVD_W-1]};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = hcg_pkg::DVS_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[hcg_pkg::DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[hcg_pkg::DVS_W-1:0];
            quo_in = {quo_ff[hcg_pkg::DVD_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

endmodule

>>> hdl/hcg_back.sv
// Back part: hit store, grouping scan, group sums and result output register.
module hcg_back (
   input  logic             clock,
   input  logic             reset,
   input  hcg_pkg::cfg_type cfg,
   input  logic             queue_empty,
   input  hcg_pkg::req_type queue_data,
   output logic             queue_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hcg_pkg::rsp_type rsp_data
);

   localparam logic [3:0] S_LOAD     = 4'd0;
   localparam logic [3:0] S_SEED_RD  = 4'd1;
   localparam logic [3:0] S_SEED_LAT = 4'd2;
   localparam logic [3:0] S_SCAN_RD  = 4'd3;
   localparam logic [3:0] S_SCAN_CHK = 4'd4;
   localparam logic [3:0] S_SQ       = 4'd5;
   localparam logic [3:0] S_DECIDE   = 4'd6;
   localparam logic [3:0] S_PROD     = 4'd7;
   localparam logic [3:0] S_ACC      = 4'd8;
   localparam logic [3:0] S_GROUP    = 4'd9;
   localparam logic [3:0] S_DIV      = 4'd10;
   localparam logic [3:0] S_BOUNDS   = 4'd11;
   localparam logic [3:0] S_EMIT     = 4'd12;
   localparam logic [3:0] S_FINISH   = 4'd13;

   hcg_pkg::hit_type hit_mem [hcg_pkg::FRAME_DEPTH];
   hcg_pkg::hit_type rd_data_ff;
   logic                      rd_en, wr_en;
   logic [hcg_pkg::IDX_W-1:0] rd_addr, wr_addr;
   hcg_pkg::hit_type          wr_data;

   logic [3:0]                        state_ff, state_in;
   logic [hcg_pkg::CNT_W-1:0]         count_ff, count_in, i_ff, i_in, j_ff, j_in;
   logic [hcg_pkg::CNT_W-1:0]         gcnt_ff, gcnt_in;
   logic [hcg_pkg::FRAME_DEPTH-1:0]   taken_ff, taken_in;
   logic [47:0]                       fb_start_ff, fb_start_in, fb_end_ff, fb_end_in;
   logic                              pend_valid_ff, pend_valid_in;
   logic                              out_valid_ff, out_valid_in;
   logic [1:0]                        k_ff, k_in;

   hcg_pkg::hit_type                  seed_ff, seed_in, sec_ff, sec_in;
   logic signed [48:0]                dt_ff, dt_in;
   logic                              win_ok_ff, win_ok_in;
   logic [34:0]                       d2_ff, d2_in;
   logic signed [hcg_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [hcg_pkg::ES_W-1:0]          es_ff, es_in, mes_ff, mes_in;
   logic [hcg_pkg::MC_W-1:0]          mcs_ff, mcs_in;
   logic signed [hcg_pkg::NUM_W-1:0]  num_ff, num_in;
   logic [47:0]                       ptime_ff, ptime_in;
   hcg_pkg::rsp_type                  pend_ff, pend_in, out_ff, out_in;

   hcg_pkg::hit_type                  h;
   logic signed [48:0]                dt_c, adt_c;
   logic [32:0]                       stop_c;
   logic signed [16:0]                dsel;
   logic signed [33:0]                sq_c;
   logic [hcg_pkg::CNT_W-1:0]         limit_c;
   logic [hcg_pkg::NUM_W-1:0]         num_abs;
   logic                              div_start, div_done;
   logic [hcg_pkg::DVD_W-1:0]         div_dvd, quotient;
   logic [hcg_pkg::DVS_W-1:0]         div_dvs;
   logic                              out_free;
   hcg_pkg::hit_type                  pos_c;
   hcg_pkg::rsp_type                  grp_rsp;

   hcg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hit_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= hit_mem[rd_addr];
      end
   end

   assign h         = rd_data_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign queue_pop = (state_ff == S_LOAD) && !queue_empty;

   assign stop_c  = {1'b0, cfg.overlap_margin} + {1'b0, cfg.time_window};
   assign dt_c    = $signed({1'b0, h.t}) - $signed({1'b0, seed_ff.t});
   assign adt_c   = dt_c[48] ? -dt_c : dt_c;
   assign limit_c = (32'(cfg.max_hits) > hcg_pkg::MAX_GROUP) ?
                    hcg_pkg::CNT_W'(hcg_pkg::MAX_GROUP) : hcg_pkg::CNT_W'(cfg.max_hits);

   always_comb begin
      case (k_ff)
         2'd0:    dsel = $signed({seed_ff.x[15], seed_ff.x}) - $signed({h.x[15], h.x});
         2'd1:    dsel = $signed({seed_ff.y[15], seed_ff.y}) - $signed({h.y[15], h.y});
         default: dsel = $signed({seed_ff.z[15], seed_ff.z}) - $signed({h.z[15], h.z});
      endcase
   end
   assign sq_c = dsel * dsel;

   assign num_abs = num_ff[hcg_pkg::NUM_W-1] ? hcg_pkg::NUM_W'(-num_ff) : num_ff;
   assign div_dvd = {num_abs, 1'b0} + hcg_pkg::DVD_W'(es_ff);
   assign div_dvs = {es_ff, 1'b0};

   // position of the lower-energy partner in a two-hit group
   assign pos_c = (gcnt_ff == hcg_pkg::CNT_W'(2) && sec_ff.e < seed_ff.e) ? sec_ff : seed_ff;

   always_comb begin
      grp_rsp.photon_valid          = 1'b1;
      grp_rsp.photon_last           = 1'b0;
      grp_rsp.photon_time           = ptime_ff;
      grp_rsp.photon_region         = seed_ff.region;
      grp_rsp.photon_x              = pos_c.x;
      grp_rsp.photon_y              = pos_c.y;
      grp_rsp.photon_z              = pos_c.z;
      grp_rsp.photon_energy         = (es_ff > hcg_pkg::ES_W'(hcg_pkg::E17_MAX)) ?
                                      hcg_pkg::E17_MAX : 17'(es_ff);
      grp_rsp.photon_missing_energy = (mes_ff > hcg_pkg::ES_W'(hcg_pkg::E17_MAX)) ?
                                      hcg_pkg::E17_MAX : 17'(mes_ff);
      grp_rsp.photon_missing_count  = 11'(mcs_ff);
      grp_rsp.photon_hit_count      = 4'(gcnt_ff);
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      gcnt_in       = gcnt_ff;
      taken_in      = taken_ff;
      fb_start_in   = fb_start_ff;
      fb_end_in     = fb_end_ff;
      pend_valid_in = pend_valid_ff;
      out_valid_in  = out_valid_ff;
      k_in          = k_ff;
      seed_in       = seed_ff;
      sec_in        = sec_ff;
      dt_in         = dt_ff;
      win_ok_in     = win_ok_ff;
      d2_in         = d2_ff;
      prod_in       = prod_ff;
      es_in         = es_ff;
      mes_in        = mes_ff;
      mcs_in        = mcs_ff;
      num_in        = num_ff;
      ptime_in      = ptime_ff;
      pend_in       = pend_ff;
      out_in        = out_ff;
      rd_en         = 1'b0;
      rd_addr       = i_ff[hcg_pkg::IDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = count_ff[hcg_pkg::IDX_W-1:0];
      div_start     = 1'b0;
      wr_data.t      = queue_data.hit_time;
      wr_data.region = queue_data.hit_region;
      wr_data.x      = queue_data.hit_x;
      wr_data.y      = queue_data.hit_y;
      wr_data.z      = queue_data.hit_z;
      wr_data.e      = queue_data.hit_energy;
      wr_data.me     = queue_data.hit_missing_energy;
      wr_data.mc     = queue_data.hit_missing_count;

      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         S_LOAD: begin
            if (!queue_empty) begin
               // a full store drops the hit, a closing item still closes the frame
               if (count_ff < hcg_pkg::CNT_W'(hcg_pkg::FRAME_DEPTH)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               if (queue_data.frame_last) begin
                  fb_start_in = queue_data.frame_start;
                  fb_end_in   = queue_data.frame_end;
                  i_in        = '0;
                  state_in    = S_SEED_RD;
               end
            end
         end
         S_SEED_RD: begin
            if (i_ff == count_ff) begin
               state_in = S_FINISH;
            end else if (taken_ff[i_ff[hcg_pkg::IDX_W-1:0]]) begin
               i_in = i_ff + 1'b1;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = i_ff[hcg_pkg::IDX_W-1:0];
               state_in = S_SEED_LAT;
            end
         end
         S_SEED_LAT: begin
            seed_in = h;
            taken_in[i_ff[hcg_pkg::IDX_W-1:0]] = 1'b1;
            gcnt_in  = hcg_pkg::CNT_W'(1);
            es_in    = hcg_pkg::ES_W'(h.e);
            mes_in   = hcg_pkg::ES_W'(h.me);
            mcs_in   = hcg_pkg::MC_W'(h.mc);
            num_in   = '0;
            j_in     = i_ff + 1'b1;
            state_in = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            if (j_ff == count_ff) begin
               state_in = S_GROUP;
            end else if (taken_ff[j_ff[hcg_pkg::IDX_W-1:0]]) begin
               j_in = j_ff + 1'b1;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = j_ff[hcg_pkg::IDX_W-1:0];
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (h.region != seed_ff.region) begin
               j_in     = j_ff + 1'b1;
               state_in = S_SCAN_RD;
            end else if (dt_c > $signed({16'b0, stop_c})) begin
               state_in = S_GROUP;
            end else begin
               dt_in     = dt_c;
               win_ok_in = $unsigned(adt_c) <= {17'b0, cfg.time_window};
               k_in      = '0;
               d2_in     = '0;
               state_in  = S_SQ;
            end
         end
         S_SQ: begin
            d2_in = d2_ff + {1'b0, sq_c};
            k_in  = k_ff + 1'b1;
            if (k_ff == 2'd2) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (d2_ff < {1'b0, cfg.radius_squared} && win_ok_ff) begin
               taken_in[j_ff[hcg_pkg::IDX_W-1:0]] = 1'b1;
               if (gcnt_ff < hcg_pkg::CNT_W'(hcg_pkg::MAX_GROUP)) begin
                  state_in = S_PROD;
               end else begin
                  // oversized group: only counted, it is discarded later
                  gcnt_in  = gcnt_ff + 1'b1;
                  j_in     = j_ff + 1'b1;
                  state_in = S_SCAN_RD;
               end
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_PROD: begin
            prod_in  = $signed(dt_ff[32:0]) * $signed({1'b0, h.e});
            state_in = S_ACC;
         end
         S_ACC: begin
            num_in = num_ff + hcg_pkg::NUM_W'(prod_ff);
            es_in  = es_ff + hcg_pkg::ES_W'(h.e);
            mes_in = mes_ff + hcg_pkg::ES_W'(h.me);
            mcs_in = mcs_ff + hcg_pkg::MC_W'(h.mc);
            if (gcnt_ff == hcg_pkg::CNT_W'(1)) begin
               sec_in = h;
            end
            gcnt_in  = gcnt_ff + 1'b1;
            j_in     = j_ff + 1'b1;
            state_in = S_SCAN_RD;
         end
         S_GROUP: begin
            if (gcnt_ff > limit_c ||
                (hcg_pkg::ESUM_W'(es_ff) + hcg_pkg::ESUM_W'(mes_ff)) <
                 hcg_pkg::ESUM_W'(cfg.energy_min) ||
                es_ff > hcg_pkg::ES_W'(cfg.energy_max)) begin
               i_in     = i_ff + 1'b1;
               state_in = S_SEED_RD;
            end else if (es_ff == '0) begin
               ptime_in = seed_ff.t;
               state_in = S_BOUNDS;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               ptime_in = num_ff[hcg_pkg::NUM_W-1] ? seed_ff.t - quotient[47:0] :
                                                      seed_ff.t + quotient[47:0];
               state_in = S_BOUNDS;
            end
         end
         S_BOUNDS: begin
            if (ptime_ff < fb_start_ff || ptime_ff >= fb_end_ff) begin
               i_in     = i_ff + 1'b1;
               state_in = S_SEED_RD;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            // one group is held back so the final one can carry photon_last
            if (out_free) begin
               out_valid_in  = pend_valid_ff;
               out_in        = pend_ff;
               pend_in       = grp_rsp;
               pend_valid_in = 1'b1;
               i_in          = i_ff + 1'b1;
               state_in      = S_SEED_RD;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               if (pend_valid_ff) begin
                  out_in             = pend_ff;
                  out_in.photon_last = 1'b1;
               end else begin
                  out_in             = '0;
                  out_in.photon_last = 1'b1;
               end
               pend_valid_in = 1'b0;
               taken_in      = '0;
               count_in      = '0;
               state_in      = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         count_ff      <= '0;
         i_ff          <= '0;
         j_ff          <= '0;
         gcnt_ff       <= '0;
         taken_ff      <= '0;
         fb_start_ff   <= '0;
         fb_end_ff     <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         k_ff          <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         gcnt_ff       <= gcnt_in;
         taken_ff      <= taken_in;
         fb_start_ff   <= fb_start_in;
         fb_end_ff     <= fb_end_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         k_ff          <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      seed_ff   <= seed_in;
      sec_ff    <= sec_in;
      dt_ff     <= dt_in;
      win_ok_ff <= win_ok_in;
      d2_ff     <= d2_in;
      prod_ff   <= prod_in;
      es_ff     <= es_in;
      mes_ff    <= mes_in;
      mcs_ff    <= mcs_in;
      num_ff    <= num_in;
      ptime_ff  <= ptime_in;
      pend_ff   <= pend_in;
      out_ff    <= out_in;
   end

endmodule

>>> hdl/hit_cluster_grouper.sv
// Hit cluster grouper top level: front, item queue and grouping back end.
// Items reach the back end through the queue; hits load one per cycle while it holds items.
// Grouping: each untaken entry seeds a group; later untaken entries of the same region are
// tested in time and distance; a kept group with energy is timed by the serial divider.
// Input stalls once the queue fills during grouping; results of a frame follow in order.
// Synchronous active-high reset clears control state and the taken flags; the hit
// store needs no clearing since only entries written in the current frame are read.
module hit_cluster_grouper (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  hcg_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output hcg_pkg::rsp_type            rsp_data,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [hcg_pkg::CSR_AW-1:0]  paddr,
   input  logic [hcg_pkg::CSR_DW-1:0]  pwdata,
   output logic [hcg_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready
);

   hcg_pkg::cfg_type       cfg;
   logic                   q_push, q_pop, q_full, q_empty;
   hcg_pkg::req_type       queue_data;

   hcg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .queue_full (q_full),
      .queue_push (q_push),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .cfg        (cfg)
   );

   hcg_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (req_data),
      .pop       (q_pop),
      .pop_data  (queue_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   hcg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .queue_empty (q_empty),
      .queue_data  (queue_data),
      .queue_pop   (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_empty))
      else $error("queue popped while empty");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("queue pushed while full");

   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.photon_valid) |-> rsp_data.photon_last)
      else $error("empty frame marker without last flag");

   a_group_size: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.photon_valid) |->
      (rsp_data.photon_hit_count != 4'd0 &&
       32'(rsp_data.photon_hit_count) <= hcg_pkg::MAX_GROUP))
      else $error("emitted group size out of range");

endmodule

>>> test/tb_hit_cluster_grouper.sv
// Self-checking testbench of the hit cluster grouper: random and directed frames.
module tb_hit_cluster_grouper;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   hcg_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   hcg_pkg::rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [hcg_pkg::CSR_AW-1:0] paddr = '0;
   logic [hcg_pkg::CSR_DW-1:0] pwdata = '0;
   logic [hcg_pkg::CSR_DW-1:0] prdata;
   logic pready;
   logic req_took = 1'b0;

   hit_cluster_grouper u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   hcg_pkg::cfg_type cfg;
   hcg_pkg::hit_type frame_hits[hcg_pkg::FRAME_DEPTH];
   int unsigned frame_fill;
   hcg_pkg::rsp_type photon_queue[$];
   hcg_pkg::req_type hit_queue[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles = 0;
   int failures = 0;
   int hits_sent = 0;
   int photons_seen = 0;
   int frames_sent = 0;
   int idle_count = 0;

   task automatic group_hits(input logic [47:0] fstart, input logic [47:0] fend);
      bit taken[hcg_pkg::FRAME_DEPTH];
      int mem[hcg_pkg::MAX_GROUP];
      int cnt, lim, nres, i, j, k;
      longint stopv, win, dt, dx, dy, dz, num, a, q;
      longint unsigned d2, es, mes, mcs;
      logic [47:0] ptime;
      hcg_pkg::hit_type s, h, pos;
      hcg_pkg::rsp_type r;
      lim = (cfg.max_hits > hcg_pkg::MAX_GROUP) ? hcg_pkg::MAX_GROUP : int'(cfg.max_hits);
      stopv = longint'(cfg.overlap_margin) + longint'(cfg.time_window);
      win = longint'(cfg.time_window);
      nres = 0;
      for (i = 0; i < hcg_pkg::FRAME_DEPTH; i++) taken[i] = 0;
      for (i = 0; i < frame_fill; i++) begin
         if (taken[i]) continue;
         taken[i] = 1;
         s = frame_hits[i];
         mem[0] = i;
         cnt = 1;
         for (j = i + 1; j < frame_fill; j++) begin
            h = frame_hits[j];
            if (taken[j] || h.region != s.region) continue;
            dt = longint'(h.t) - longint'(s.t);
            if (dt > stopv) break;
            dx = longint'(s.x) - longint'(h.x);
            dy = longint'(s.y) - longint'(h.y);
            dz = longint'(s.z) - longint'(h.z);
            d2 = dx * dx + dy * dy + dz * dz;
            if (dt < 0) dt = -dt;
            if (d2 < cfg.radius_squared && dt <= win) begin
               taken[j] = 1;
               if (cnt < hcg_pkg::MAX_GROUP) mem[cnt] = j;
               cnt++;
            end
         end
         if (cnt > lim) continue;
         es = 0; mes = 0; mcs = 0; num = 0;
         for (k = 0; k < cnt; k++) begin
            h = frame_hits[mem[k]];
            es += 64'(h.e); mes += 64'(h.me); mcs += 64'(h.mc);
            if (k > 0) num += (longint'(h.t) - longint'(s.t)) * longint'(h.e);
         end
         if (es + mes < cfg.energy_min || es > cfg.energy_max) continue;
         ptime = s.t;
         if (es != 0) begin
            a = (num < 0) ? -num : num;
            q = (2 * a + longint'(es)) / (2 * longint'(es));
            ptime = (num < 0) ? ptime - q[47:0] : ptime + q[47:0];
         end
         if (ptime < fstart || ptime >= fend) continue;
         pos = s;
         if (cnt == 2 && frame_hits[mem[1]].e < s.e) pos = frame_hits[mem[1]];
         r = '0;
         r.photon_valid = 1'b1;
         r.photon_time = ptime;
         r.photon_region = s.region;
         r.photon_x = pos.x;
         r.photon_y = pos.y;
         r.photon_z = pos.z;
         r.photon_energy = (es > hcg_pkg::E17_MAX) ? hcg_pkg::E17_MAX : es[16:0];
         r.photon_missing_energy = (mes > hcg_pkg::E17_MAX) ? hcg_pkg::E17_MAX : mes[16:0];
         r.photon_missing_count = mcs[10:0];
         r.photon_hit_count = cnt[3:0];
         photon_queue.push_back(r);
         nres++;
      end
      if (nres == 0) begin
         r = '0;
         r.photon_last = 1'b1;
         photon_queue.push_back(r);
      end else begin
         photon_queue[$].photon_last = 1'b1;
      end
   endtask

   task automatic predict_hit(input hcg_pkg::req_type it);
      hcg_pkg::hit_type h;
      if (frame_fill < hcg_pkg::FRAME_DEPTH) begin
         h.t = it.hit_time; h.region = it.hit_region;
         h.x = it.hit_x; h.y = it.hit_y; h.z = it.hit_z;
         h.e = it.hit_energy; h.me = it.hit_missing_energy; h.mc = it.hit_missing_count;
         frame_hits[frame_fill] = h;
         frame_fill++;
      end
      if (it.frame_last) begin
         group_hits(it.frame_start, it.frame_end);
         frame_fill = 0;
      end
   endtask

   // input acceptance as seen at the rising edge
   always @(posedge clock) begin
      req_took <= !reset && req_valid && !req_stall;
   end

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_took) begin
            predict_hit(req_data);
            hits_sent++;
         end
         if ((!req_valid || req_took) && hit_queue.size() > 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            req_data <= hit_queue.pop_front();
            req_valid <= 1'b1;
         end else if (!req_valid || req_took) begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall, with one long hold-off in the last phase
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         photons_seen++;
         if (photon_queue.size() == 0) begin
            $error("unexpected photon %p", rsp_data);
            failures++;
         end else begin
            hcg_pkg::rsp_type e;
            e = photon_queue.pop_front();
            if (e.photon_valid !== rsp_data.photon_valid) begin
               $error("photon_valid exp %0d got %0d", e.photon_valid, rsp_data.photon_valid);
               failures++;
            end
            if (e.photon_last !== rsp_data.photon_last) begin
               $error("photon_last exp %0d got %0d", e.photon_last, rsp_data.photon_last);
               failures++;
            end
            if (e.photon_time !== rsp_data.photon_time) begin
               $error("photon_time exp %0d got %0d", e.photon_time, rsp_data.photon_time);
               failures++;
            end
            if (e.photon_region !== rsp_data.photon_region) begin
               $error("photon_region exp %0d got %0d", e.photon_region,
                      rsp_data.photon_region);
               failures++;
            end
            if (e.photon_x !== rsp_data.photon_x) begin
               $error("photon_x exp %0d got %0d", e.photon_x, rsp_data.photon_x);
               failures++;
            end
            if (e.photon_y !== rsp_data.photon_y) begin
               $error("photon_y exp %0d got %0d", e.photon_y, rsp_data.photon_y);
               failures++;
            end
            if (e.photon_z !== rsp_data.photon_z) begin
               $error("photon_z exp %0d got %0d", e.photon_z, rsp_data.photon_z);
               failures++;
            end
            if (e.photon_energy !== rsp_data.photon_energy) begin
               $error("photon_energy exp %0d got %0d", e.photon_energy,
                      rsp_data.photon_energy);
               failures++;
            end
            if (e.photon_missing_energy !== rsp_data.photon_missing_energy) begin
               $error("photon_missing_energy exp %0d got %0d", e.photon_missing_energy,
                      rsp_data.photon_missing_energy);
               failures++;
            end
            if (e.photon_missing_count !== rsp_data.photon_missing_count) begin
               $error("photon_missing_count exp %0d got %0d", e.photon_missing_count,
                      rsp_data.photon_missing_count);
               failures++;
            end
            if (e.photon_hit_count !== rsp_data.photon_hit_count) begin
               $error("photon_hit_count exp %0d got %0d", e.photon_hit_count,
                      rsp_data.photon_hit_count);
               failures++;
            end
         end
      end
   end

   // watchdog: cycles with no item moving on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
         idle_count <= 0;
      end else if (idle_count >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   task automatic csr_write(input logic [2:0] index, input logic [63:0] value);
      @(negedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= hcg_pkg::CSR_AW'(8 * index); pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (index)
         hcg_pkg::REG_RADIUS_SQUARED: cfg.radius_squared = value[33:0];
         hcg_pkg::REG_TIME_WINDOW:    cfg.time_window = value[31:0];
         hcg_pkg::REG_OVERLAP_MARGIN: cfg.overlap_margin = value[31:0];
         hcg_pkg::REG_MAX_HITS:       cfg.max_hits = value[3:0];
         hcg_pkg::REG_ENERGY_MIN:     cfg.energy_min = value[16:0];
         hcg_pkg::REG_ENERGY_MAX:     cfg.energy_max = value[16:0];
         default: ;
      endcase
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   task automatic set_config(input logic [33:0] rad, input logic [31:0] win,
                             input logic [31:0] ovl, input logic [3:0] mh,
                             input logic [16:0] emin, input logic [16:0] emax);
      csr_write(hcg_pkg::REG_RADIUS_SQUARED, 64'(rad));
      csr_write(hcg_pkg::REG_TIME_WINDOW, 64'(win));
      csr_write(hcg_pkg::REG_OVERLAP_MARGIN, 64'(ovl));
      csr_write(hcg_pkg::REG_MAX_HITS, 64'(mh));
      csr_write(hcg_pkg::REG_ENERGY_MIN, 64'(emin));
      csr_write(hcg_pkg::REG_ENERGY_MAX, 64'(emax));
   endtask

   // let the block drain, then wait out a possible trailing grouping pass
   task automatic drain();
      while (hit_queue.size() > 0 || req_valid || photon_queue.size() > 0)
         @(posedge clock);
      repeat (40000) @(posedge clock);
   endtask

   function automatic hcg_pkg::req_type rand_hit();
      hcg_pkg::req_type it;
      it = '0;
      it.hit_time = 48'({$urandom, $urandom});
      it.hit_region = 16'($urandom);
      it.hit_x = 16'($urandom);
      it.hit_y = 16'($urandom);
      it.hit_z = 16'($urandom);
      it.hit_energy = 16'($urandom);
      it.hit_missing_energy = 16'($urandom);
      it.hit_missing_count = 8'($urandom);
      it.frame_start = 48'({$urandom, $urandom});
      it.frame_end = 48'({$urandom, $urandom});
      return it;
   endfunction

   // well-formed frame: sorted times, few regions, close positions
   task automatic queue_frame(input int n, input bit wide_bounds);
      hcg_pkg::req_type it;
      logic [47:0] t;
      logic [15:0] reg_base;
      int i;
      t = 48'({$urandom, $urandom} >> 2);
      reg_base = 16'($urandom);
      for (i = 0; i < n; i++) begin
         it = rand_hit();
         t += 48'($urandom_range(0, 3000));
         it.hit_time = t;
         it.hit_region = reg_base + 16'($urandom_range(0, 2));
         it.hit_x = 16'($signed($urandom_range(0, 80)) - 40);
         it.hit_y = 16'($signed($urandom_range(0, 80)) - 40);
         it.hit_z = 16'($signed($urandom_range(0, 80)) - 40);
         if ($urandom_range(0, 9) == 0) it.hit_energy = 0;
         it.frame_last = (i == n - 1);
         if (wide_bounds) begin
            it.frame_start = 48'd0;
            it.frame_end = '1;
         end
         hit_queue.push_back(it);
      end
      frames_sent++;
   endtask

   initial begin
      hcg_pkg::req_type it;
      int i, n;
      cfg = '0;
      cfg.max_hits = 4'd8;
      cfg.energy_max = hcg_pkg::E17_MAX;
      frame_fill = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes of every field, empty frame, zero energy group
      set_config(34'h3FFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 4'd15, 17'd0, hcg_pkg::E17_MAX);
      it = '0; it.frame_last = 1'b1;
      hit_queue.push_back(it);                  // single hit, empty bounds
      it = '1; it.frame_start = '0; it.frame_end = '1; it.frame_last = 1'b0;
      hit_queue.push_back(it);
      it.hit_time = '1; it.hit_x = 16'sh8000; it.hit_y = 16'sh8000;
      it.hit_z = 16'sh8000; it.frame_last = 1'b1;
      hit_queue.push_back(it);
      for (i = 0; i < 3; i++) begin
         it = '0; it.hit_time = 48'(i * 10); it.hit_region = 16'd7;
         it.frame_end = '1; it.frame_last = (i == 2);
         hit_queue.push_back(it);               // all zero energy
      end
      for (i = 0; i < 2; i++) begin
         it = '0; it.hit_time = 48'(100 + i * 7); it.hit_region = 16'hFFFF;
         it.hit_energy = (i == 0) ? 16'hFFFF : 16'd3;
         it.hit_missing_energy = 16'hFFFF; it.hit_missing_count = 8'hFF;
         it.hit_x = 16'sh7FFF; it.hit_y = -16'sd5; it.hit_z = 16'sd9;
         it.frame_end = '1; it.frame_last = (i == 1);
         hit_queue.push_back(it);               // two hits, lower second energy
      end
      drain();
      set_config(34'd0, 32'd0, 32'd0, 4'd0, hcg_pkg::E17_MAX, 17'd0);
      queue_frame(4, 1'b1);                     // everything rejected
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 65 : 0;
         recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 20 : 0;
         case (phase)
            0: set_config(34'd1600, 32'd5000, 32'd2000, 4'd8, 17'd0, hcg_pkg::E17_MAX);
            1: set_config(34'd900, 32'd3000, 32'd0, 4'd3, 17'd500, 17'd100000);
            default: set_config(34'd6000, 32'd8000, 32'd10000, 4'd2, 17'd0,
                                hcg_pkg::E17_MAX);
         endcase
         if (phase == 2) hold_cycles = 3000;
         while (hits_sent + hit_queue.size() < 40 + 120 * (phase + 1)) begin
            n = $urandom_range(1, 10);
            if ($urandom_range(0, 19) == 0) begin
               for (i = 0; i < n; i++) begin
                  it = rand_hit();
                  it.frame_last = (i == n - 1);
                  hit_queue.push_back(it);
               end
            end else begin
               queue_frame(n, $urandom_range(0, 3) != 0);
            end
         end
         if (phase == 2) begin
            // overfull frame: hits beyond the store are dropped
            for (i = 0; i < hcg_pkg::FRAME_DEPTH + 3; i++) begin
               it = rand_hit();
               it.hit_time = 48'(i);
               it.frame_start = '0; it.frame_end = '1;
               it.frame_last = (i == hcg_pkg::FRAME_DEPTH + 2);
               hit_queue.push_back(it);
            end
         end
         drain();
      end

      $display("tb: %0d hits in %0d+ frames, %0d results checked, 3 stall profiles",
               hits_sent, frames_sent, photons_seen);
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
